### design/c2d_pkg.sv
// Shared types, register codes and reset values for the 3x3 convolution filter.
`timescale 1ns / 1ps
`default_nettype none

package c2d_pkg;

	localparam int NTAPS   = 9;
	localparam int TAP_W   = 12;
	localparam int PROD_W  = 20;
	localparam int ACC_W   = 24;
	localparam int ROW_W   = 13;
	localparam int MAX_ROWS = 4096;
	localparam int CFG_DW  = 60;
	localparam int CFG_AW  = 2;

	localparam logic [CFG_AW-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_AW-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_AW-1:0] REG_WLOW   = 2'd2;
	localparam logic [CFG_AW-1:0] REG_WHIGH  = 2'd3;

	localparam logic [11:0] WIDTH_RST  = 12'd640;
	localparam logic [12:0] HEIGHT_RST = 13'd480;
	// sharpen kernel: 0 -1 0 / -1 5 -1 / 0 -1 0 in Q4.8
	localparam logic [59:0] WLOW_RST   = 60'h500_F00_000_F00_000;
	localparam logic [47:0] WHIGH_RST  = 48'h000_F00_000_F00;

	typedef logic signed [TAP_W-1:0]  tap_t;
	typedef logic [7:0]               sample_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		logic ld2;
		logic ld3;
	} stage_ctl_t;

	function automatic prod_t tap_mul(tap_t w, sample_t s);
		logic signed [PROD_W:0] p;
		p = w * $signed({1'b0, s});
		return p[PROD_W-1:0];
	endfunction

	// round half up, clamp to 0..255
	function automatic sample_t round_sat(logic signed [ACC_W-1:0] acc);
		logic [ACC_W-1:0] t;
		sample_t r;
		t = $unsigned(acc) + ACC_W'(128);
		if (acc < 0)
			r = '0;
		else if (t[ACC_W-1:8] > (ACC_W-8)'(255))
			r = 8'hFF;
		else
			r = t[15:8];
		return r;
	endfunction

endpackage

`default_nettype wire

### design/c2d_stream_if.sv
// Valid/ready channel interfaces for pixels in and filtered pixels out.
`timescale 1ns / 1ps
`default_nettype none

interface c2d_pix_in_if;
	logic       valid;
	logic       ready;
	logic       flush;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	logic [7:0] in_alpha;

	modport source (output valid, flush, in_red, in_green, in_blue, in_alpha, input ready);
	modport sink   (input valid, flush, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface c2d_pix_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;
	logic       frame_end;

	modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_end,
		input ready);
	modport sink   (input valid, out_red, out_green, out_blue, out_alpha, frame_end,
		output ready);
endinterface

`default_nettype wire

### design/c2d_line_buf.sv
// One line buffer: single write port, registered read with old-data-on-collision.
`timescale 1ns / 1ps
`default_nettype none

module c2d_line_buf #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (rd_en)
			rdata <= mem[addr];
		if (wr_en)
			mem[addr] <= wdata;
	end

endmodule

`default_nettype wire

### design/c2d_tap_mac.sv
// One channel of the 3x3 kernel: registered products, then sum, round and clamp.
`timescale 1ns / 1ps
`default_nettype none

module c2d_tap_mac (
	input  wire logic                clk,
	input  wire c2d_pkg::stage_ctl_t ctl,
	input  wire c2d_pkg::sample_t    samp [c2d_pkg::NTAPS],
	input  wire c2d_pkg::tap_t       taps [c2d_pkg::NTAPS],
	output c2d_pkg::sample_t         result
);

	c2d_pkg::prod_t prod_s2 [c2d_pkg::NTAPS];
	logic signed [c2d_pkg::ACC_W-1:0] sum;

	always_ff @(posedge clk) begin
		if (ctl.ld2) begin
			for (int i = 0; i < c2d_pkg::NTAPS; i++)
				prod_s2[i] <= c2d_pkg::tap_mul(taps[i], samp[i]);
		end
	end

	always_comb begin
		sum = '0;
		for (int i = 0; i < c2d_pkg::NTAPS; i++)
			sum = sum + c2d_pkg::ACC_W'(prod_s2[i]);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld3)
			result <= c2d_pkg::round_sat(sum);
	end

endmodule

`default_nettype wire

### design/conv2d_clamp_edge_filter_unit.sv
// Top level of the streaming 3x3 convolution filter with clamped image edges.
//
//  channel  | dir | transfer when       | payload
//  ---------+-----+---------------------+------------------------------------------
//  pixels   | in  | valid && ready      | flush, in_red, in_green, in_blue, in_alpha
//  results  | out | valid && ready      | out_red .. out_alpha, frame_end
//  cfg      | in  | cfg_we              | cfg_index, cfg_data (no read-back)
//
// One pixel per clock while results are taken; a result passes the line buffer read,
// the product register and the result register.
// Each row ends in a column compare; line buffers are two single-port RAMs
// read and written at the column address in the same cycle.
// Reset clears position, window and valids; line buffers are not cleared.
// A held result stalls only the stages behind it that are full.
`timescale 1ns / 1ps
`default_nettype none

module conv2d_clamp_edge_filter_unit #(
	parameter int MAX_WIDTH = 2048,
	parameter int CHANNELS  = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	c2d_pix_in_if.sink                        pixels,
	c2d_pix_out_if.source                     results,
	input  wire logic                         cfg_we,
	input  wire logic [c2d_pkg::CFG_AW-1:0]   cfg_index,
	input  wire logic [c2d_pkg::CFG_DW-1:0]   cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = 8 * CHANNELS;
	localparam int RW = c2d_pkg::ROW_W;

	// configuration
	logic [11:0] width_q;
	logic [12:0] height_q;
	logic [59:0] wlow_q;
	logic [47:0] whigh_q;
	logic        restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= c2d_pkg::WIDTH_RST;
			height_q <= c2d_pkg::HEIGHT_RST;
			wlow_q   <= c2d_pkg::WLOW_RST;
			whigh_q  <= c2d_pkg::WHIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				c2d_pkg::REG_WIDTH:  width_q  <= cfg_data[11:0];
				c2d_pkg::REG_HEIGHT: height_q <= cfg_data[12:0];
				c2d_pkg::REG_WLOW:   wlow_q   <= cfg_data[59:0];
				c2d_pkg::REG_WHIGH:  whigh_q  <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	assign restart = cfg_we && (cfg_index == c2d_pkg::REG_WIDTH ||
		cfg_index == c2d_pkg::REG_HEIGHT);

	logic [CW-1:0] w_last;
	logic [RW-1:0] h_eff;

	always_comb begin
		if (width_q == '0)
			w_last = '0;
		else if (32'(width_q) > 32'(MAX_WIDTH))
			w_last = CW'(MAX_WIDTH - 1);
		else
			w_last = CW'(32'(width_q) - 32'd1);
		if (height_q == '0)
			h_eff = RW'(1);
		else if (32'(height_q) > 32'(c2d_pkg::MAX_ROWS))
			h_eff = RW'(c2d_pkg::MAX_ROWS);
		else
			h_eff = height_q;
	end

	c2d_pkg::tap_t taps [c2d_pkg::NTAPS];

	always_comb begin
		for (int i = 0; i < 5; i++)
			taps[i] = wlow_q[12*i +: 12];
		for (int i = 0; i < 4; i++)
			taps[5+i] = whigh_q[12*i +: 12];
	end

	// flow control
	logic v_s1, v_s2, v_s3;
	logic ld3_ok, rdy2, rdy1, acc, fire1;

	assign ld3_ok = !v_s3 || results.ready;
	assign rdy2   = !v_s2 || ld3_ok;
	assign rdy1   = !v_s1 || rdy2;
	assign acc    = pixels.valid && rdy1;
	assign fire1  = v_s1 && rdy2;
	assign pixels.ready = rdy1;

	// stream position
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          ws_q;
	logic          row_end, is_last, is_emit, in_frame;

	assign row_end  = col_q == w_last;
	assign in_frame = row_q < h_eff;
	assign is_last  = col_q == '0 && row_q == h_eff + RW'(1);
	assign is_emit  = row_q >= RW'(2) || (row_q == RW'(1) && col_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ws_q  <= 1'b0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
			ws_q  <= 1'b0;
		end else if (acc) begin
			if (is_last) begin
				col_q <= '0;
				row_q <= '0;
				ws_q  <= 1'b0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
				if (in_frame)
					ws_q <= !ws_q;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// incoming pixel, zero on flush
	logic [7:0]    chan_in [4];
	logic [PW-1:0] pix;

	assign chan_in[0] = pixels.in_red;
	assign chan_in[1] = pixels.in_green;
	assign chan_in[2] = pixels.in_blue;
	assign chan_in[3] = pixels.in_alpha;

	always_comb begin
		for (int c = 0; c < CHANNELS; c++)
			pix[8*c +: 8] = pixels.flush ? 8'h00 : chan_in[c];
	end

	// line buffers alternate by row: ws_q holds the row being written,
	// the other buffer holds the row above
	logic [PW-1:0] line0_s1, line1_s1;
	logic          wr_ok;

	assign wr_ok = acc && in_frame;

	c2d_line_buf #(.DEPTH(MAX_WIDTH), .WIDTH(PW)) u_line0 (
		.clk   (clk),
		.rd_en (acc),
		.wr_en (wr_ok && !ws_q),
		.addr  (col_q),
		.wdata (pix),
		.rdata (line0_s1)
	);

	c2d_line_buf #(.DEPTH(MAX_WIDTH), .WIDTH(PW)) u_line1 (
		.clk   (clk),
		.rd_en (acc),
		.wr_en (wr_ok && ws_q),
		.addr  (col_q),
		.wdata (pix),
		.rdata (line1_s1)
	);

	logic [PW-1:0] pix_s1;
	logic ws_s1, top_mid_s1, bot_mid_s1, emit_s1, last_s1, c0_s1, c1_s1, w1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (rdy1)
			v_s1 <= acc;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1     <= pix;
			ws_s1      <= ws_q;
			top_mid_s1 <= row_q == RW'(1);
			bot_mid_s1 <= !in_frame;
			emit_s1    <= is_emit;
			last_s1    <= is_last;
			c0_s1      <= col_q == '0;
			c1_s1      <= col_q == CW'(1);
			w1_s1      <= w_last == '0;
		end
	end

	// vertical triple for this column, edges clamped
	logic [PW-1:0] mid, old2;
	logic [PW-1:0] trip [3];

	assign mid     = ws_s1 ? line0_s1 : line1_s1;
	assign old2    = ws_s1 ? line1_s1 : line0_s1;
	assign trip[0] = top_mid_s1 ? mid : old2;
	assign trip[1] = mid;
	assign trip[2] = bot_mid_s1 ? mid : pix_s1;

	// window: [0] oldest column, [2] newest
	logic [PW-1:0] win_q [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++)
				for (int j = 0; j < 3; j++)
					win_q[k][j] <= '0;
		end else if (restart) begin
			for (int k = 0; k < 3; k++)
				for (int j = 0; j < 3; j++)
					win_q[k][j] <= '0;
		end else if (fire1) begin
			for (int j = 0; j < 3; j++) begin
				win_q[0][j] <= win_q[1][j];
				win_q[1][j] <= win_q[2][j];
				win_q[2][j] <= trip[j];
			end
		end
	end

	// clamp left and right neighbors at row edges
	logic [PW-1:0] col_l [3], col_c [3], col_r [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			col_c[j] = win_q[2][j];
			if (!c0_s1) begin
				col_r[j] = trip[j];
				col_l[j] = c1_s1 ? win_q[2][j] : win_q[1][j];
			end else begin
				col_r[j] = win_q[2][j];
				col_l[j] = w1_s1 ? win_q[2][j] : win_q[1][j];
			end
		end
	end

	c2d_pkg::stage_ctl_t ctl;
	logic last_s2, last_s3;

	assign ctl.ld2 = fire1 && emit_s1;
	assign ctl.ld3 = v_s2 && ld3_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy2)
				v_s2 <= v_s1 && emit_s1;
			if (ld3_ok)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld2)
			last_s2 <= last_s1;
		if (ctl.ld3)
			last_s3 <= last_s2;
	end

	c2d_pkg::sample_t res [4];

	for (genvar c = 0; c < 4; c++) begin : g_chan
		if (c < CHANNELS) begin : g_mac
			c2d_pkg::sample_t samp [c2d_pkg::NTAPS];

			always_comb begin
				for (int j = 0; j < 3; j++) begin
					samp[3*j]     = col_l[j][8*c +: 8];
					samp[3*j + 1] = col_c[j][8*c +: 8];
					samp[3*j + 2] = col_r[j][8*c +: 8];
				end
			end

			c2d_tap_mac u_mac (
				.clk    (clk),
				.ctl    (ctl),
				.samp   (samp),
				.taps   (taps),
				.result (res[c])
			);
		end else begin : g_zero
			assign res[c] = '0;
		end
	end

	assign results.valid     = v_s3;
	assign results.out_red   = res[0];
	assign results.out_green = res[1];
	assign results.out_blue  = res[2];
	assign results.out_alpha = res[3];
	assign results.frame_end = last_s3;

`ifndef SYNTHESIS
	// a held result must not let a queued product fall out of stage 2
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !results.ready && v_s2 |=> v_s2)
		else $error("product stage lost while result held");

	// buffer select changes only at a row end, at the last item of a frame or on restart
	a_ws_flip: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(ws_q) |-> $past(acc && (row_end || is_last)) || $past(restart))
		else $error("line buffer select changed mid-row");

	// an emitting item accepted at the input implies a full window row above it
	a_emit_row: assert property (@(posedge clk) disable iff (!arst_n)
		acc && is_emit |-> row_q != '0)
		else $error("emit flagged on first row");
`endif

endmodule

`default_nettype wire

### bench/c2d_filter_watch.sv
// Channel monitor for the 3x3 filter: predicts every filtered pixel and compares.
`timescale 1ns / 1ps

module c2d_filter_watch #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                       clk,
	input  logic                       arst_n,
	c2d_pix_in_if                      pixels,
	c2d_pix_out_if                     results,
	input  logic                       cfg_we,
	input  logic [c2d_pkg::CFG_AW-1:0] cfg_index,
	input  logic [c2d_pkg::CFG_DW-1:0] cfg_data,
	output int                         mismatches,
	output int                         results_due
);

	localparam int MAX_HEIGHT = 4096;
	localparam int PRINT_CAP  = 60;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       frame_end;
	} filtered_px_t;

	filtered_px_t due_q[$];

	logic [11:0] width_reg;
	logic [12:0] height_reg;
	logic [59:0] wlow_reg;
	logic [47:0] whigh_reg;

	// two line buffers: newest row at [col], the one before at [MAX_WIDTH + col]
	logic [31:0] line_mem [2*MAX_WIDTH];
	// three vertical triples, oldest column first
	logic [31:0] win [9];
	int unsigned in_col;
	int unsigned in_row;
	int unsigned out_count;

	initial begin
		mismatches  = 0;
		results_due = 0;
		out_count   = 0;
	end

	function automatic int unsigned eff_width();
		if (width_reg == 0)
			return 1;
		if (int'(width_reg) > MAX_WIDTH)
			return MAX_WIDTH;
		return int'(width_reg);
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg == 0)
			return 1;
		if (int'(height_reg) > MAX_HEIGHT)
			return MAX_HEIGHT;
		return int'(height_reg);
	endfunction

	function automatic int tap_weight(int i);
		logic [11:0] raw;
		raw = (i < 5) ? wlow_reg[12*i +: 12] : whigh_reg[12*(i-5) +: 12];
		return raw[11] ? int'(raw) - 4096 : int'(raw);
	endfunction

	task automatic restart_frame();
		in_col = 0;
		in_row = 0;
		foreach (win[i])
			win[i] = '0;
	endtask

	task automatic report_mismatch(string msg);
		if (mismatches < PRINT_CAP)
			$display("%0t ns  mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
				out_count, name, got, want));
	endtask

	task automatic write_register(logic [c2d_pkg::CFG_AW-1:0] idx,
		logic [c2d_pkg::CFG_DW-1:0] data);
		case (idx)
			c2d_pkg::REG_WIDTH: begin
				width_reg = data[11:0];
				restart_frame();
			end
			c2d_pkg::REG_HEIGHT: begin
				height_reg = data[12:0];
				restart_frame();
			end
			c2d_pkg::REG_WLOW:  wlow_reg = data[59:0];
			c2d_pkg::REG_WHIGH: whigh_reg = data[47:0];
			default: ;
		endcase
	endtask

	// Advance the stream by one transfer; queue the filtered pixel it releases.
	task automatic convolve_item(logic flush, logic [31:0] sample);
		int unsigned w, h, pc, pr;
		logic [31:0] pix, mid, packed_out;
		logic [31:0] trip [3];
		logic [31:0] cols [3][3];
		logic emit, last;
		int acc, r, c, j, k;
		filtered_px_t px;

		w = eff_width();
		h = eff_height();
		pc = in_col;
		pr = in_row;
		if (pc >= w || pr > h + 1) begin
			restart_frame();
			pc = 0;
			pr = 0;
		end

		pix = flush ? 32'h0 : sample;
		mid = line_mem[pc];
		trip[0] = (pr == 1) ? mid : line_mem[MAX_WIDTH + pc];
		trip[1] = mid;
		// below the last row, repeat the bottom row
		trip[2] = (pr >= h) ? mid : pix;
		if (pr < h) begin
			line_mem[MAX_WIDTH + pc] = mid;
			line_mem[pc] = pix;
		end

		emit = (pr >= 2) || (pr == 1 && pc >= 1);
		last = (pc == 0 && pr == h + 1);

		if (emit) begin
			for (j = 0; j < 3; j++) begin
				cols[1][j] = win[6+j];
				if (pc >= 1) begin
					cols[2][j] = trip[j];
					cols[0][j] = (pc == 1) ? win[6+j] : win[3+j];
				end else begin
					// right edge of the previous row: clamp the right column
					cols[2][j] = win[6+j];
					cols[0][j] = (w == 1) ? win[6+j] : win[3+j];
				end
			end
			packed_out = '0;
			for (c = 0; c < 4; c++) begin
				acc = 0;
				for (j = 0; j < 3; j++)
					for (k = 0; k < 3; k++)
						acc += tap_weight(j*3 + k) * int'((cols[k][j] >> (8*c)) & 32'hFF);
				if (acc < 0) begin
					r = 0;
				end else begin
					r = (acc + 128) >> 8;
					if (r > 255)
						r = 255;
				end
				packed_out[8*c +: 8] = 8'(r);
			end
			px.red       = packed_out[7:0];
			px.green     = packed_out[15:8];
			px.blue      = packed_out[23:16];
			px.alpha     = packed_out[31:24];
			px.frame_end = last;
			due_q.push_back(px);
		end

		for (j = 0; j < 3; j++) begin
			win[j]   = win[3+j];
			win[3+j] = win[6+j];
			win[6+j] = trip[j];
		end

		if (last) begin
			in_col = 0;
			in_row = 0;
		end else begin
			pc++;
			if (pc >= w) begin
				pc = 0;
				pr++;
			end
			in_col = pc;
			in_row = pr;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		filtered_px_t want;
		if (!arst_n) begin
			width_reg  = 12'd640;
			height_reg = 13'd480;
			wlow_reg   = 60'h500_F00_000_F00_000;
			whigh_reg  = 48'h000_F00_000_F00;
			foreach (line_mem[i])
				line_mem[i] = '0;
			restart_frame();
			due_q.delete();
		end else begin
			if (cfg_we)
				write_register(cfg_index, cfg_data);
			// compare before queueing: a pixel taken now cannot leave now
			if (results.valid && results.ready) begin
				if (due_q.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with none due", out_count));
				end else begin
					want = due_q.pop_front();
					check_field("red", results.out_red, want.red);
					check_field("green", results.out_green, want.green);
					check_field("blue", results.out_blue, want.blue);
					check_field("alpha", results.out_alpha, want.alpha);
					check_field("frame_end", {7'b0, results.frame_end}, {7'b0, want.frame_end});
				end
				out_count++;
			end
			if (pixels.valid && pixels.ready)
				convolve_item(pixels.flush, {pixels.in_alpha, pixels.in_blue,
					pixels.in_green, pixels.in_red});
		end
		results_due = due_q.size();
	end

endmodule

### bench/conv2d_clamp_edge_filter_unit_test.sv
// Testbench top: streams frames and register writes into the 3x3 filter and gives the verdict.
`timescale 1ns / 1ps

module conv2d_clamp_edge_filter_unit_test;

	localparam int MAX_W         = 2048;
	localparam int MAX_H         = 4096;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 460;

	typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_e;
	typedef enum int {
		K_RANDOM, K_SMALL, K_IDENTITY, K_ZERO, K_MAX, K_MIN, K_SHARPEN, K_BOX
	} kernel_kind_e;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [c2d_pkg::CFG_AW-1:0] cfg_index;
	logic [c2d_pkg::CFG_DW-1:0] cfg_data;

	int mismatches;
	int results_due;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_requests = 0;
	int holds_done = 0;
	int hold_left = 0;
	int items_sent = 0;
	int cycles = 0;
	int cur_w = 1;
	int cur_h = 1;

	c2d_pix_in_if  pixels();
	c2d_pix_out_if results();

	conv2d_clamp_edge_filter_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pixels),
		.results   (results),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	c2d_filter_watch #(
		.MAX_WIDTH (MAX_W)
	) u_watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixels      (pixels),
		.results     (results),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.results_due (results_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else if (hold_left > 0) begin
			results.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (holds_done != hold_requests) begin
			holds_done++;
			hold_left = HOLD_CYCLES - 1;
			results.ready <= 1'b0;
		end else begin
			results.ready <= (int'($urandom_range(99)) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** conv2d_clamp_edge_filter_unit: FAILED **");
			$finish;
		end
	end

	function automatic logic [31:0] rand_pixel();
		logic [31:0] px;
		int c;
		for (c = 0; c < 4; c++)
			case ($urandom_range(9))
				0: px[8*c +: 8] = 8'h00;
				1: px[8*c +: 8] = 8'hFF;
				default: px[8*c +: 8] = 8'($urandom);
			endcase
		return px;
	endfunction

	task automatic apply_idling(idle_mode_e mode);
		tx_idle_pct  = (mode == IDLE_TX) ? 61 : (mode == IDLE_BOTH) ? 19 : 0;
		rx_stall_pct = (mode == IDLE_RX) ? 61 : (mode == IDLE_BOTH) ? 19 : 0;
	endtask

	task automatic cfg_write(logic [c2d_pkg::CFG_AW-1:0] idx,
		logic [c2d_pkg::CFG_DW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Raw values go out as given (upper bits junk); keep the clamped size for framing.
	task automatic set_geometry(int w_raw, int h_raw);
		logic [59:0] junk;
		int w12, h13;
		junk = 60'({$urandom, $urandom});
		cfg_write(c2d_pkg::REG_WIDTH, {junk[59:12], 12'(w_raw)});
		junk = 60'({$urandom, $urandom});
		cfg_write(c2d_pkg::REG_HEIGHT, {junk[59:13], 13'(h_raw)});
		w12 = w_raw & 'hFFF;
		h13 = h_raw & 'h1FFF;
		cur_w = (w12 < 1) ? 1 : (w12 > MAX_W) ? MAX_W : w12;
		cur_h = (h13 < 1) ? 1 : (h13 > MAX_H) ? MAX_H : h13;
	endtask

	task automatic set_kernel(kernel_kind_e kind);
		logic [107:0] taps;
		logic [11:0] t;
		logic [59:0] junk;
		int i;
		for (i = 0; i < 9; i++) begin
			case (kind)
				K_RANDOM:   t = 12'($urandom);
				K_SMALL:    t = 12'($urandom_range(256) - 128);
				K_IDENTITY: t = (i == 4) ? 12'h100 : 12'h000;
				K_ZERO:     t = 12'h000;
				K_MAX:      t = 12'h7FF;
				K_MIN:      t = 12'h800;
				K_SHARPEN:  t = (i == 4) ? 12'h500 : (i % 2 == 1) ? 12'hF00 : 12'h000;
				default:    t = 12'h01C;
			endcase
			taps[12*i +: 12] = t;
		end
		cfg_write(c2d_pkg::REG_WLOW, taps[59:0]);
		junk = 60'({$urandom, $urandom});
		cfg_write(c2d_pkg::REG_WHIGH, {junk[59:48], taps[107:60]});
	endtask

	// Drain: no pixel offered, nothing due, then let the pipeline settle.
	task automatic wait_idle();
		pixels.valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_item(logic fl, logic [31:0] px);
		if (tx_idle_pct != 0 && int'($urandom_range(99)) < tx_idle_pct) begin
			pixels.valid <= 1'b0;
			do @(posedge clk); while (int'($urandom_range(99)) < tx_idle_pct);
		end
		pixels.valid    <= 1'b1;
		pixels.flush    <= fl;
		pixels.in_red   <= px[7:0];
		pixels.in_green <= px[15:8];
		pixels.in_blue  <= px[23:16];
		pixels.in_alpha <= px[31:24];
		do @(posedge clk); while (!pixels.ready);
		items_sent++;
	endtask

	// One frame at the current size plus its flush tail; stop early at cut_at,
	// swap the kernel at split_at.
	task automatic run_frame(int cut_at, int split_at);
		int area, total, p;
		area  = cur_w * cur_h;
		total = area + cur_w + 1;
		for (p = 0; p < total && p != cut_at; p++) begin
			if (p == split_at) begin
				wait_idle();
				set_kernel(kernel_kind_e'($urandom_range(7)));
			end
			if (p < area)
				send_item($urandom_range(99) < 5, rand_pixel());
			else
				send_item($urandom_range(99) >= 20, rand_pixel());
		end
	endtask

	initial begin
		int i, target, frame_no, total, cut, split, w_raw, h_raw;
		logic broken, do_geo, do_kern;

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = c2d_pkg::REG_WIDTH;
		cfg_data        = '0;
		pixels.valid    = 1'b0;
		pixels.flush    = 1'b0;
		pixels.in_red   = 8'h00;
		pixels.in_green = 8'h00;
		pixels.in_blue  = 8'h00;
		pixels.in_alpha = 8'h00;
		results.ready   = 1'b0;
		apply_idling(IDLE_NONE);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry and sharpen kernel: first row and a few outputs
		for (i = 0; i < 645; i++)
			send_item(1'b0, rand_pixel());

		// 3x2 with extremes, a hole inside the frame and a pixel in the tail
		wait_idle();
		set_geometry(3, 2);
		send_item(1'b0, 32'h00FF00FF);
		send_item(1'b0, 32'hFF00FF00);
		send_item(1'b1, 32'hFFFFFFFF);
		send_item(1'b0, 32'hFFFFFFFF);
		send_item(1'b0, 32'h00000000);
		send_item(1'b0, 32'h80FF0001);
		send_item(1'b1, 32'h00000000);
		send_item(1'b0, 32'hFFFFFFFF);
		send_item(1'b1, 32'hFFFFFFFF);
		send_item(1'b1, 32'h00000000);

		// zero width and height clamp to a single pixel
		wait_idle();
		set_kernel(K_IDENTITY);
		set_geometry(0, 0);
		send_item(1'b0, 32'hA5C33C5A);
		send_item(1'b0, 32'hFFFFFFFF);
		send_item(1'b1, 32'h00000000);

		wait_idle();
		set_kernel(K_MAX);
		set_geometry(2, 3);
		for (i = 0; i < 6; i++)
			send_item(1'b0, {4{8'(i * 51)}});
		for (i = 0; i < 3; i++)
			send_item(1'b1, 32'h00000000);

		// hold results off long enough to back up the input
		wait_idle();
		set_kernel(K_SHARPEN);
		set_geometry(8, 8);
		hold_requests++;
		run_frame(-1, -1);

		target   = items_sent + RANDOM_ITEMS;
		frame_no = 0;
		broken   = 1'b1;
		while (items_sent < target) begin
			apply_idling(idle_mode_e'(frame_no % 4));
			do_geo  = broken || ($urandom_range(99) < 60);
			do_kern = ($urandom_range(99) < 35);
			if (do_geo || do_kern)
				wait_idle();
			if (do_geo) begin
				case ($urandom_range(9))
					0: w_raw = 1;
					1: w_raw = 2;
					8: w_raw = $urandom_range(40, 11);
					9: w_raw = 0;
					default: w_raw = $urandom_range(10, 3);
				endcase
				case ($urandom_range(9))
					7: h_raw = 0;
					8: h_raw = $urandom_range(16, 7);
					9: h_raw = 1;
					default: h_raw = $urandom_range(6, 1);
				endcase
				set_geometry(w_raw, h_raw);
			end
			if (do_kern)
				set_kernel(kernel_kind_e'($urandom_range(7)));
			total = cur_w * cur_h + cur_w + 1;
			cut   = -1;
			split = -1;
			case ($urandom_range(9))
				0: cut = int'($urandom_range(total - 1));
				1: split = int'($urandom_range(total - 1));
				default: ;
			endcase
			run_frame(cut, split);
			broken = (cut >= 0);
			frame_no++;
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("** conv2d_clamp_edge_filter_unit: PASSED **");
		end else begin
			$display("** conv2d_clamp_edge_filter_unit: FAILED **");
		end
		$finish;
	end

endmodule

### sim.f
design/c2d_pkg.sv
design/c2d_stream_if.sv
design/c2d_line_buf.sv
design/c2d_tap_mac.sv
design/conv2d_clamp_edge_filter_unit.sv
bench/c2d_filter_watch.sv
bench/conv2d_clamp_edge_filter_unit_test.sv
